// File: rtl/mssd_pkg.sv
// shared types, constants and the segment decoder for the seven-segment driver
`default_nettype none

package mssd_pkg;

    // display geometry
    localparam int DIGITS = 4;
    localparam int DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // field widths
    localparam int OP_W   = 3;
    localparam int POS_W  = 2;
    localparam int CHAR_W = 8;
    localparam int NUM_W  = 16;
    localparam int MAX_W  = 14;
    localparam int SEG_W  = 7;
    localparam int IDX_W  = 2;

    // decimal conversion: one shift per binary bit, four bcd digits
    localparam int BCD_DIGITS = 4;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int STEPS      = MAX_W;
    localparam int STEP_W     = $clog2(STEPS);
    localparam int CNT_W      = 3;

    localparam logic [CHAR_W-1:0] CODE_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CODE_ZERO  = 8'h30;
    localparam logic [MAX_W-1:0]  SHOW_LIMIT = 14'd9999;
    localparam logic [MAX_W-1:0]  MAX_RESET  = 14'd9999;

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_WRITE_CHAR = 3'd1,
        OP_WRITE_DOT  = 3'd2,
        OP_WRITE_NUM  = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CONV,
        S_STORE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic tick_load;
        logic write_char;
        logic write_dot;
        logic clear;
        logic sat_load;
        logic conv_step;
        logic num_store;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_op  op;
        logic out_free;
    } t_stat;

    // character code to segment pattern, bit0 a through bit6 g
    function automatic logic [SEG_W-1:0] decode_segments(input logic [CHAR_W-1:0] c);
        logic [3:0]       v_val;
        logic [SEG_W-1:0] v_seg;
        v_val = 4'hF;
        v_seg = 7'h00;
        if (c <= 8'd9) begin
            v_val = c[3:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v_val = c[3:0];
        end
        unique case (v_val)
            4'd0: v_seg = 7'h3F;
            4'd1: v_seg = 7'h06;
            4'd2: v_seg = 7'h5B;
            4'd3: v_seg = 7'h4F;
            4'd4: v_seg = 7'h66;
            4'd5: v_seg = 7'h6D;
            4'd6: v_seg = 7'h7D;
            4'd7: v_seg = 7'h07;
            4'd8: v_seg = 7'h7F;
            4'd9: v_seg = 7'h6F;
            default: begin
                unique case (c)
                    8'h41:   v_seg = 7'h77; // A
                    8'h43:   v_seg = 7'h39; // C
                    8'h45:   v_seg = 7'h79; // E
                    8'h46:   v_seg = 7'h71; // F
                    8'h48:   v_seg = 7'h76; // H
                    8'h4A:   v_seg = 7'h0E; // J
                    8'h4C:   v_seg = 7'h38; // L
                    8'h50:   v_seg = 7'h73; // P
                    8'h55:   v_seg = 7'h3E; // U
                    8'h2D:   v_seg = 7'h40; // dash
                    default: v_seg = 7'h00;
                endcase
            end
        endcase
        return v_seg;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mssd_ctrl.sv
// controller state machine sequencing each accepted beat through the datapath
`default_nettype none

module mssd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  mssd_pkg::t_stat  i_stat,
    output mssd_pkg::t_cmd   o_cmd
);

    mssd_pkg::t_state                 r_state, n_state;
    logic [mssd_pkg::STEP_W-1:0]      r_step, n_step;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mssd_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mssd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = mssd_pkg::S_EXEC;
                end
            end
            mssd_pkg::S_EXEC: begin
                n_state = mssd_pkg::S_IDLE;
                unique case (i_stat.op)
                    mssd_pkg::OP_TICK: begin
                        // hold the tick until the output register can take it
                        if (i_stat.out_free) begin
                            o_cmd.tick_load = 1'b1;
                        end else begin
                            n_state = mssd_pkg::S_EXEC;
                        end
                    end
                    mssd_pkg::OP_WRITE_CHAR: o_cmd.write_char = 1'b1;
                    mssd_pkg::OP_WRITE_DOT:  o_cmd.write_dot  = 1'b1;
                    mssd_pkg::OP_CLEAR:      o_cmd.clear      = 1'b1;
                    mssd_pkg::OP_WRITE_NUM: begin
                        o_cmd.sat_load = 1'b1;
                        n_step         = '0;
                        n_state        = mssd_pkg::S_CONV;
                    end
                    default: n_state = mssd_pkg::S_IDLE;
                endcase
            end
            mssd_pkg::S_CONV: begin
                o_cmd.conv_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == mssd_pkg::STEP_W'(mssd_pkg::STEPS - 1)) begin
                    n_state = mssd_pkg::S_STORE;
                end
            end
            mssd_pkg::S_STORE: begin
                o_cmd.num_store = 1'b1;
                n_state         = mssd_pkg::S_IDLE;
            end
            default: n_state = mssd_pkg::S_IDLE;
        endcase
    end

    // conversion never runs past the last binary bit
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mssd_pkg::S_CONV) |-> (r_step < mssd_pkg::STEP_W'(mssd_pkg::STEPS)))
        else $error("conversion step counter out of range");

    // a tick result is only loaded when the output register is free
    a_tick_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tick_load |-> i_stat.out_free)
        else $error("tick loaded over a pending result");

    // a number store must follow a conversion step
    a_store_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.num_store |-> $past(o_cmd.conv_step))
        else $error("number stored without conversion");

endmodule

`default_nettype wire

// File: rtl/mssd_dp.sv
// datapath: item latch, display stores, scan index, decimal converter, output register
`default_nettype none

module mssd_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mssd_pkg::t_cmd               i_cmd,
    output mssd_pkg::t_stat              o_stat,
    input  wire [mssd_pkg::OP_W-1:0]     i_op,
    input  wire [mssd_pkg::POS_W-1:0]    i_position,
    input  wire [mssd_pkg::CHAR_W-1:0]   i_character,
    input  wire                          i_dot_on,
    input  wire [mssd_pkg::NUM_W-1:0]    i_number,
    input  wire                          i_cfg_we,
    input  wire [mssd_pkg::MAX_W-1:0]    i_cfg_wdata,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [mssd_pkg::IDX_W-1:0]   o_digit_index,
    output logic [mssd_pkg::SEG_W-1:0]   o_segments,
    output logic                         o_dot_lit
);

    // latched item
    mssd_pkg::t_op                       r_op;
    logic [mssd_pkg::POS_W-1:0]          r_pos;
    logic [mssd_pkg::CHAR_W-1:0]         r_char_in;
    logic                                r_dot_in;
    logic [mssd_pkg::NUM_W-1:0]          r_num;

    // stores and scan
    logic [mssd_pkg::CHAR_W-1:0]         r_chars [mssd_pkg::DIGITS];
    logic [mssd_pkg::DIGITS-1:0]         r_dots;
    logic [mssd_pkg::DIG_W-1:0]          r_scan;
    logic [mssd_pkg::MAX_W-1:0]          r_max;

    // converter
    logic [mssd_pkg::MAX_W-1:0]          r_bin;
    logic [mssd_pkg::BCD_W-1:0]          r_bcd;

    // output register
    logic                                r_out_valid;
    logic [mssd_pkg::IDX_W-1:0]          r_idx;
    logic [mssd_pkg::SEG_W-1:0]          r_seg;
    logic                                r_dot_out;

    logic [mssd_pkg::DIG_W-1:0]          w_next;
    logic [mssd_pkg::MAX_W-1:0]          w_limit;
    logic [mssd_pkg::MAX_W-1:0]          w_sat;
    logic [mssd_pkg::BCD_W-1:0]          w_bcd_adj;
    logic [mssd_pkg::CNT_W-1:0]          w_cnt;
    logic [mssd_pkg::CNT_W-1:0]          w_k   [mssd_pkg::DIGITS];
    logic [mssd_pkg::CNT_W-1:0]          w_sel [mssd_pkg::DIGITS];
    logic [mssd_pkg::DIGITS-1:0]         w_num_we;
    logic [3:0]                          w_num_dig [mssd_pkg::DIGITS];

    assign o_stat.op       = r_op;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // next scan position, wrapping after the last digit
    assign w_next = (r_scan == mssd_pkg::DIG_W'(mssd_pkg::DIGITS - 1)) ? '0 : r_scan + 1'b1;

    // saturate to the register and to four decimal digits
    assign w_limit = (r_max > mssd_pkg::SHOW_LIMIT) ? mssd_pkg::SHOW_LIMIT : r_max;
    assign w_sat   = (r_num > {2'b00, w_limit}) ? w_limit : r_num[mssd_pkg::MAX_W-1:0];

    // add-three adjust of every bcd digit before the shift
    always_comb begin
        for (int d = 0; d < mssd_pkg::BCD_DIGITS; d++) begin
            w_bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ?
                                  r_bcd[4*d +: 4] + 4'd3 : r_bcd[4*d +: 4];
        end
    end

    // significant digit count, at least one
    always_comb begin
        priority if (r_bcd[15:12] != 4'd0) w_cnt = 3'd4;
        else if (r_bcd[11:8] != 4'd0)      w_cnt = 3'd3;
        else if (r_bcd[7:4] != 4'd0)       w_cnt = 3'd2;
        else                               w_cnt = 3'd1;
    end

    // per-entry digit placement, most significant digit at the position
    always_comb begin
        for (int e = 0; e < mssd_pkg::DIGITS; e++) begin
            w_k[e]       = mssd_pkg::CNT_W'(e) - {1'b0, r_pos};
            w_sel[e]     = w_cnt - 3'd1 - w_k[e];
            w_num_we[e]  = ({1'b0, r_pos} <= mssd_pkg::CNT_W'(e)) && (w_k[e] < w_cnt);
            w_num_dig[e] = r_bcd[{w_sel[e][1:0], 2'b00} +: 4];
        end
    end

    // item latch on an accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op      <= mssd_pkg::t_op'(i_op);
            r_pos     <= i_position;
            r_char_in <= i_character;
            r_dot_in  <= i_dot_on;
            r_num     <= i_number;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= mssd_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    // character and dot stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < mssd_pkg::DIGITS; e++) begin
                r_chars[e] <= mssd_pkg::CODE_BLANK;
            end
            r_dots <= '0;
        end else if (i_cmd.clear) begin
            for (int e = 0; e < mssd_pkg::DIGITS; e++) begin
                r_chars[e] <= mssd_pkg::CODE_BLANK;
            end
            r_dots <= '0;
        end else begin
            for (int e = 0; e < mssd_pkg::DIGITS; e++) begin
                if (i_cmd.write_char && ({1'b0, r_pos} == mssd_pkg::CNT_W'(e))) begin
                    r_chars[e] <= r_char_in;
                end
                if (i_cmd.write_dot && ({1'b0, r_pos} == mssd_pkg::CNT_W'(e))) begin
                    r_dots[e] <= r_dot_in;
                end
                if (i_cmd.num_store && w_num_we[e]) begin
                    r_chars[e] <= mssd_pkg::CODE_ZERO | {4'h0, w_num_dig[e]};
                end
            end
        end
    end

    // shift-and-add-three binary to bcd converter
    always_ff @(posedge i_clk) begin
        if (i_cmd.sat_load) begin
            r_bin <= w_sat;
            r_bcd <= '0;
        end else if (i_cmd.conv_step) begin
            r_bin <= {r_bin[mssd_pkg::MAX_W-2:0], 1'b0};
            r_bcd <= {w_bcd_adj[mssd_pkg::BCD_W-2:0], r_bin[mssd_pkg::MAX_W-1]};
        end
    end

    // scan index and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tick_load) begin
                r_scan      <= w_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_load) begin
            r_idx     <= mssd_pkg::IDX_W'(w_next);
            r_seg     <= mssd_pkg::decode_segments(r_chars[w_next]);
            r_dot_out <= r_dots[w_next];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_digit_index = r_idx;
    assign o_segments    = r_seg;
    assign o_dot_lit     = r_dot_out;

    // a loaded tick is presented on the next cycle with the new scan index
    a_tick_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_load |=> (r_out_valid && (r_idx == mssd_pkg::IDX_W'(r_scan))))
        else $error("tick result not presented");

    // a freshly loaded converter value never exceeds four decimal digits
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.sat_load) |-> (r_bin <= mssd_pkg::SHOW_LIMIT))
        else $error("saturated value beyond display range");

    // the presented digit index is always a real digit
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_idx <= mssd_pkg::IDX_W'(mssd_pkg::DIGITS - 1)))
        else $error("digit index beyond display");

endmodule

`default_nettype wire

// File: rtl/multiplexed_seven_segment_driver.sv
// top level of the multiplexed seven-segment display driver
//
//  channel   direction  handshake                     payload
//  in        input      i_in_valid / o_in_ready       op, position, character, dot_on, number
//  out       output     o_out_valid / i_out_ready     digit_index, segments, dot_lit
//  cfg       input      i_cfg_we                      max_value (i_cfg_wdata)
//
// each beat is taken in the idle state and run in the execute state; tick, character,
// dot and clear beats end there, and a number beat is saturated there and then goes
// through the 14-step shift-and-add-three converter and a store state
// a tick waits in the controller only while the output register still holds an untaken beat
// synchronous active-low reset: all characters blank, dots off, scan index 0, max 9999
`default_nettype none

module multiplexed_seven_segment_driver (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [mssd_pkg::OP_W-1:0]     i_op,
    input  wire [mssd_pkg::POS_W-1:0]    i_position,
    input  wire [mssd_pkg::CHAR_W-1:0]   i_character,
    input  wire                          i_dot_on,
    input  wire [mssd_pkg::NUM_W-1:0]    i_number,
    input  wire                          i_cfg_we,
    input  wire [mssd_pkg::MAX_W-1:0]    i_cfg_wdata,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [mssd_pkg::IDX_W-1:0]   o_digit_index,
    output logic [mssd_pkg::SEG_W-1:0]   o_segments,
    output logic                         o_dot_lit
);

    mssd_pkg::t_cmd  w_cmd;
    mssd_pkg::t_stat w_stat;

    // sequencer
    mssd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // stores, converter and output register
    mssd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_character   (i_character),
        .i_dot_on      (i_dot_on),
        .i_number      (i_number),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digit_index (o_digit_index),
        .o_segments    (o_segments),
        .o_dot_lit     (o_dot_lit)
    );

endmodule

`default_nettype wire
